>>> rtl/core/ioredir_pkg.sv
package ioredir_pkg;

    localparam int LEGACY_IRQS_DEF = 16;
    localparam int GSI_W           = 8;
    localparam int FLAGS_W         = 4;
    localparam int IRQ_W           = 8;
    localparam int VEC_W           = 8;
    localparam int APIC_W          = 8;
    localparam int WORD_W          = 16;
    localparam int IN_DATA_W       = 40;
    localparam int OUT_DATA_W      = 40;

    localparam logic [7:0] RED_BASE = 8'h10;
    localparam int BIT_ACTIVE_LOW   = 13;
    localparam int BIT_LEVEL        = 15;

    // two-bit mode codes, polarity in flags[1:0], trigger in flags[3:2]
    localparam logic [1:0] POL_HIGH   = 2'b01;
    localparam logic [1:0] POL_LOW    = 2'b11;
    localparam logic [1:0] TRIG_EDGE  = 2'b01;
    localparam logic [1:0] TRIG_LEVEL = 2'b11;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_MAP  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [GSI_W-1:0]   gsi;
    } t_entry;

    typedef struct packed {
        logic                 we;
        logic                 re;
    } t_tbl_ctl;

endpackage

>>> rtl/core/irq_override_to_redirection_entry.sv
// Channel  Dir  Signals                                   Content
// -------  ---  ----------------------------------------  ------------------------------
// s_axis   in   s_axis_tvalid/tready/tdata[39:0]/tuser[0]  load or map request beat
// m_axis   out  m_axis_tvalid/tready/tdata[39:0]           redirection entry fields
//
// One beat per cycle sustained while m_axis_tready is high. A map beat passes the table read,
// then the output register, before it is valid on m_axis; an m_axis stall can hold it in
// the read stage. Load beats give no output.
// The override table is a 16x12 synchronous memory read at the accept edge; a load
// writes at its own accept edge, so a following map always sees it.
// Reset: synchronous, active low; clears the per-entry valid bits so every entry
// reads as IRQ i -> GSI i, flags zero.
// Stalls: the output register plus the read stage hold two results; s_axis_tready
// drops only when both are full and m_axis_tready is low.
module irq_override_to_redirection_entry
    import ioredir_pkg::*;
#(
    parameter int LEGACY_IRQS = LEGACY_IRQS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] irq, [15:8] override_gsi, [19:16] override_flags, [27:20] apic_id,
    // [28] fallback_low, [29] edge_trigger, [37:30] vector, [39:38] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] register_index, [23:8] low_word, [31:24] destination, [39:32] resolved_gsi
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (LEGACY_IRQS > 1) ? $clog2(LEGACY_IRQS) : 1;

    // input unpack
    t_kind              in_kind;
    logic [IRQ_W-1:0]   in_irq;
    t_entry             in_entry;
    logic [APIC_W-1:0]  in_apic;
    logic               in_low;
    logic               in_edge;
    logic [VEC_W-1:0]   in_vec;
    logic               in_tab;
    logic               accept;
    logic               out_ld;
    t_tbl_ctl           tbl_ctl;
    t_entry             rd_entry;

    assign in_kind        = t_kind'(s_axis_tuser[0]);
    assign in_irq         = s_axis_tdata[7:0];
    assign in_entry.gsi   = s_axis_tdata[15:8];
    assign in_entry.flags = s_axis_tdata[19:16];
    assign in_apic        = s_axis_tdata[27:20];
    assign in_low         = s_axis_tdata[28];
    assign in_edge        = s_axis_tdata[29];
    assign in_vec         = s_axis_tdata[37:30];
    assign in_tab         = (in_irq < IRQ_W'(LEGACY_IRQS));

    // read stage (table read in flight)
    logic               r_s1_valid;
    logic               r_s1_tab;
    logic [IRQ_W-1:0]   r_s1_irq;
    logic [APIC_W-1:0]  r_s1_apic;
    logic               r_s1_low;
    logic               r_s1_edge;
    logic [VEC_W-1:0]   r_s1_vec;

    // output register
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    assign out_ld        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_ld;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign tbl_ctl.we = accept && (in_kind == KIND_LOAD) && in_tab;
    assign tbl_ctl.re = accept && (in_kind == KIND_MAP) && in_tab;

    ioredir_table #(
        .DEPTH (LEGACY_IRQS),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_idx      (in_irq[IDX_W-1:0]),
        .i_wr_entry (in_entry),
        .o_rd_entry (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= accept && (in_kind == KIND_MAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_tab  <= in_tab;
            r_s1_irq  <= in_irq;
            r_s1_apic <= in_apic;
            r_s1_low  <= in_low;
            r_s1_edge <= in_edge;
            r_s1_vec  <= in_vec;
        end
    end

    // resolve modes and compose the redirection fields
    logic               res_low;
    logic               res_edge;
    logic [GSI_W-1:0]   res_gsi;
    logic [WORD_W-1:0]  res_word;
    logic [7:0]         res_index;

    always_comb begin
        res_low  = r_s1_low;
        res_edge = r_s1_edge;
        res_gsi  = r_s1_irq;
        if (r_s1_tab) begin
            if (rd_entry.flags[1:0] == POL_LOW) begin
                res_low = 1'b1;
            end else if (rd_entry.flags[1:0] == POL_HIGH) begin
                res_low = 1'b0;
            end
            if (rd_entry.flags[3:2] == TRIG_EDGE) begin
                res_edge = 1'b1;
            end else if (rd_entry.flags[3:2] == TRIG_LEVEL) begin
                res_edge = 1'b0;
            end
            res_gsi = rd_entry.gsi;
        end
        res_word                 = {{(WORD_W-VEC_W){1'b0}}, r_s1_vec};
        res_word[BIT_ACTIVE_LOW] = res_low;
        res_word[BIT_LEVEL]      = !res_edge;
        // 0x10 + 2*gsi, wraps at 8 bits
        res_index  = RED_BASE + {res_gsi[GSI_W-2:0], 1'b0};
        n_out_data = {res_gsi, r_s1_apic, res_word, res_index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // a load beat never occupies the read stage
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (in_kind == KIND_LOAD) |=> !r_s1_valid)
        else $error("load beat entered read stage");

    // a map beat always enters the read stage
    a_map_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (in_kind == KIND_MAP) |=> r_s1_valid)
        else $error("map beat lost at read stage");

    // a read result moves to an empty output register
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |=> r_out_valid)
        else $error("read result not moved to output");

    // input stalls only when both stages are full and the sink stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without cause");
`endif

endmodule

>>> rtl/core/ioredir_table.sv
module ioredir_table
    import ioredir_pkg::*;
#(
    parameter int DEPTH = LEGACY_IRQS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tbl_ctl         i_ctl,
    input  logic [IDX_W-1:0] i_idx,
    input  t_entry           i_wr_entry,
    output t_entry           o_rd_entry
);

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_entry             r_rd_data;
    logic               r_rd_valid;
    logic [IDX_W-1:0]   r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_idx] <= i_wr_entry;
        end
        if (i_ctl.re) begin
            r_rd_data <= r_mem[i_idx];
            r_rd_idx  <= i_idx;
        end
    end

    // unwritten entries read as the identity mapping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.we) begin
                r_valid[i_idx] <= 1'b1;
            end
            if (i_ctl.re) begin
                r_rd_valid <= r_valid[i_idx];
            end
        end
    end

    always_comb begin
        if (r_rd_valid) begin
            o_rd_entry = r_rd_data;
        end else begin
            o_rd_entry.flags = '0;
            o_rd_entry.gsi   = GSI_W'(r_rd_idx);
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

// Legacy IRQ override / I/O APIC redirection entry: stream-level check.
// Load beats fill the override table, map beats are translated through it.
// Each accepted map beat is predicted in order; each m_axis beat is compared
// field by field against the oldest prediction.
module tb_top;
    import ioredir_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES    = 8;     // two-stage pipe plus margin
    localparam int RANDOM_BEATS    = 1600;

    // s_axis tdata layout, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  vector;
        logic        edge_trig;
        logic        low_pol;
        logic [7:0]  apic_id;
        logic [3:0]  ovr_flags;
        logic [7:0]  ovr_gsi;
        logic [7:0]  irq;
    } req_beat_t;

    // m_axis tdata layout
    typedef struct packed {
        logic [7:0]  resolved_gsi;
        logic [7:0]  destination;
        logic [15:0] low_word;
        logic [7:0]  reg_index;
    } redir_beat_t;

    // ------------------------------------------------------------------
    // Redirection scoreboard: own copy of the override table, queue of
    // redirection entries still owed by the block.
    // ------------------------------------------------------------------
    class redir_scoreboard;
        t_entry      ovr_table [LEGACY_IRQS_DEF];
        redir_beat_t owed_entries [$];
        int          mismatches;

        function new();
            for (int i = 0; i < LEGACY_IRQS_DEF; i++) begin
                ovr_table[i].gsi   = GSI_W'(i);
                ovr_table[i].flags = '0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return owed_entries.size();
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
        endtask

        // Called on every accepted s_axis beat.
        function void note_request(t_kind kind, req_beat_t req);
            redir_beat_t ent;
            logic        act_low;
            logic        is_edge;
            logic [7:0]  gsi;
            logic [1:0]  pol;
            logic [1:0]  trig;

            if (kind == KIND_LOAD) begin
                // sources at or above the legacy range are dropped
                if (req.irq < LEGACY_IRQS_DEF) begin
                    ovr_table[req.irq].gsi   = req.ovr_gsi;
                    ovr_table[req.irq].flags = req.ovr_flags;
                end
                return;
            end

            act_low = req.low_pol;
            is_edge = req.edge_trig;
            gsi     = req.irq;
            if (req.irq < LEGACY_IRQS_DEF) begin
                pol  = ovr_table[req.irq].flags[1:0];
                trig = ovr_table[req.irq].flags[3:2];
                if (pol == POL_LOW)
                    act_low = 1'b1;
                else if (pol == POL_HIGH)
                    act_low = 1'b0;
                if (trig == TRIG_EDGE)
                    is_edge = 1'b1;
                else if (trig == TRIG_LEVEL)
                    is_edge = 1'b0;
                gsi = ovr_table[req.irq].gsi;
            end

            ent.reg_index                 = RED_BASE + {gsi[6:0], 1'b0};  // mod 256
            ent.low_word                  = {8'h00, req.vector};
            ent.low_word[BIT_ACTIVE_LOW]  = act_low;
            ent.low_word[BIT_LEVEL]       = ~is_edge;
            ent.destination               = req.apic_id;
            ent.resolved_gsi              = gsi;
            owed_entries.push_back(ent);
        endfunction

        // Called on every accepted m_axis beat.
        task check_entry(logic [OUT_DATA_W-1:0] data);
            redir_beat_t got;
            redir_beat_t want;

            got = data;
            if (owed_entries.size() == 0) begin
                report("beat with nothing owed", data[15:0], 16'h0);
                return;
            end
            want = owed_entries.pop_front();
            if (got.reg_index !== want.reg_index)
                report("register_index", {8'h0, got.reg_index}, {8'h0, want.reg_index});
            if (got.low_word !== want.low_word)
                report("low_word", got.low_word, want.low_word);
            if (got.destination !== want.destination)
                report("destination", {8'h0, got.destination}, {8'h0, want.destination});
            if (got.resolved_gsi !== want.resolved_gsi)
                report("resolved_gsi", {8'h0, got.resolved_gsi},
                       {8'h0, want.resolved_gsi});
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // irq, override_gsi, override_flags, apic_id,
                                           // fallback_low, edge_trigger, vector, pad
    logic [0:0]            s_axis_tuser;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // register_index, low_word, destination,
                                           // resolved_gsi

    redir_scoreboard sb;
    bit              calm;   // no gaps and no back-pressure while set

    irq_override_to_redirection_entry u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Drive one beat and hold it until the block takes it. Entered and left
    // right after a rising edge; valid stays high across back-to-back beats.
    task automatic send_beat(t_kind kind, req_beat_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, req);
    endtask

    task automatic do_beat(t_kind kind, logic [7:0] irq, logic [7:0] ovr_gsi,
                           logic [3:0] ovr_flags, logic [7:0] apic_id,
                           logic low_pol, logic edge_trig, logic [7:0] vector);
        req_beat_t req;
        req.pad       = '0;
        req.irq       = irq;
        req.ovr_gsi   = ovr_gsi;
        req.ovr_flags = ovr_flags;
        req.apic_id   = apic_id;
        req.low_pol   = low_pol;
        req.edge_trig = edge_trig;
        req.vector    = vector;
        send_beat(kind, req);
    endtask

    // Sink: ready runs mixed with stalls, mostly short, sometimes long.
    initial begin
        int r;
        int len;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (calm || r < 50) begin
                m_axis_tready <= 1'b1;
                len = $urandom_range(1, 20);
            end else if (r < 90) begin
                m_axis_tready <= 1'b0;
                len = $urandom_range(1, 4);
            end else begin
                m_axis_tready <= 1'b0;
                len = $urandom_range(10, 40);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    // Output monitor: sample at the edge, before the block's registers move.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_entry(m_axis_tdata);
    end

    // Watchdog: a stretch with no beat on either side means a hang.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_CYCLES) begin
                $display("irq_override_to_redirection_entry test failed");
                $finish;
            end
        end
    end

    initial begin
        int         r;
        t_kind      kind;
        logic [7:0] irq;

        sb = new();
        calm = 1'b1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_LOAD;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: back-to-back, so a map right after its load checks forwarding
        // reset table, identity mapping with both fallback combinations
        do_beat(KIND_MAP, 8'd0, 8'h00, 4'h0, 8'h00, 1'b0, 1'b1, 8'h00);
        do_beat(KIND_MAP, 8'd15, 8'h00, 4'h0, 8'h01, 1'b1, 1'b0, 8'h30);
        // high IRQ goes straight through with fallback modes
        do_beat(KIND_MAP, 8'd16, 8'h00, 4'hF, 8'hA5, 1'b1, 1'b1, 8'h5A);
        // largest IRQ: register index wraps
        do_beat(KIND_MAP, 8'd255, 8'hFF, 4'hF, 8'hFF, 1'b1, 1'b0, 8'hFF);
        // forced active low + level overrides fallback
        do_beat(KIND_LOAD, 8'd3, 8'hFF, 4'b1111, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd3, 8'h00, 4'h0, 8'h12, 1'b0, 1'b1, 8'h40);
        // forced active high + edge
        do_beat(KIND_LOAD, 8'd4, 8'h80, 4'b0101, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd4, 8'h00, 4'h0, 8'h34, 1'b1, 1'b0, 8'h41);
        // codes 10 keep the fallback, both ways
        do_beat(KIND_LOAD, 8'd5, 8'h00, 4'b1010, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd5, 8'h00, 4'h0, 8'h56, 1'b1, 1'b0, 8'h42);
        do_beat(KIND_MAP, 8'd5, 8'h00, 4'h0, 8'h78, 1'b0, 1'b1, 8'h43);
        // loads of high sources are dropped
        do_beat(KIND_LOAD, 8'd16, 8'h22, 4'hF, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd16, 8'h00, 4'h0, 8'h9A, 1'b0, 1'b1, 8'h44);
        do_beat(KIND_LOAD, 8'd255, 8'h33, 4'hF, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd255, 8'h00, 4'h0, 8'hBC, 1'b0, 1'b0, 8'h45);
        // near-wrap and exact-wrap of the register index
        do_beat(KIND_LOAD, 8'd0, 8'h77, 4'b0011, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd0, 8'h00, 4'h0, 8'hDE, 1'b0, 1'b1, 8'h46);
        do_beat(KIND_LOAD, 8'd15, 8'h78, 4'b1100, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd15, 8'h00, 4'h0, 8'hF0, 1'b1, 1'b1, 8'h47);
        // overwrite an entry and reread it
        do_beat(KIND_LOAD, 8'd15, 8'h0F, 4'b0000, 8'h00, 1'b0, 1'b0, 8'h00);
        do_beat(KIND_MAP, 8'd15, 8'h00, 4'h0, 8'h0F, 1'b1, 1'b0, 8'h48);

        // --- random: mostly legacy-range IRQs so loads and maps meet
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            calm = ((n / 100) % 4) == 3;
            kind = ($urandom_range(0, 99) < 45) ? KIND_LOAD : KIND_MAP;
            r = $urandom_range(0, 99);
            if (r < 80)
                irq = 8'($urandom_range(0, LEGACY_IRQS_DEF - 1));
            else if (r < 88)
                irq = 8'($urandom_range(LEGACY_IRQS_DEF, LEGACY_IRQS_DEF + 3));
            else
                irq = 8'($urandom_range(0, 255));
            do_beat(kind, irq, 8'($urandom), 4'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom), 8'($urandom));
        end

        s_axis_tvalid <= 1'b0;
        calm = 1'b1;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("irq_override_to_redirection_entry test passed");
        else
            $display("irq_override_to_redirection_entry test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ioredir_pkg.sv
rtl/core/ioredir_table.sv
rtl/core/irq_override_to_redirection_entry.sv
verif/tb_top.sv
